// ===== sv/cfp_pkg.sv =====
`timescale 1ns / 1ps

package cfp_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_REG   = 2'd1;
    localparam logic [1:0] REQ_UNREG = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // result codes carried in result_kind
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_UNREG = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // frame delimiters and command byte masks
    localparam logic [7:0] START_BYTE = 8'hA5;
    localparam logic [7:0] TAIL_BYTE  = 8'h5A;
    localparam logic [7:0] LOW6_MASK  = 8'h3F;
    localparam logic [7:0] GROUP_MASK = 8'hC0;

    // code table: one row per command code, one bit per group
    localparam int TAB_ROWS   = 256;
    localparam int TAB_GROUPS = 4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [1:0] cmd_group;
        logic [7:0] cmd_code;
        logic [7:0] param_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       success;
        logic [1:0] frame_group;
        logic [7:0] frame_code;
        logic [7:0] frame_subcode;
        logic [7:0] frame_param_len;
        logic [7:0] param_data;
    } t_out_word;

endpackage

// ===== sv/command_frame_parser_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                  word
// input     in         i_in_valid / o_in_stall    cfp_pkg::t_in_word  i_in_data
// output    out        o_out_valid / i_out_stall  cfp_pkg::t_out_word o_out_data
//
// one word accepted per cycle unless the input is stalled; its result (if any) is
// loaded into the output register as the word moves out of the memory read stage
// the code table port is read at acceptance, written back when the word leaves the stage
// reset runs a clearing pass over the 256 code table rows (input stalled)
// an output stall holds the result register; a word waiting behind it holds the
// read stage and stalls the input, words with no result pass through regardless

module command_frame_parser_core #(
    parameter int PARAM_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cfp_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cfp_pkg::t_out_word o_out_data
);

    localparam int PAW = $clog2(PARAM_DEPTH);
    localparam int TAW = $clog2(cfp_pkg::TAB_ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD1,
        ST_CODE,
        ST_SUB,
        ST_LEN,
        ST_PARM,
        ST_TAIL
    } t_state;

    // memories: code valid table (row = code, bit = group) and parameter store
    logic [cfp_pkg::TAB_GROUPS-1:0] r_tab_mem [cfp_pkg::TAB_ROWS];
    logic [7:0]                     r_par_mem [PARAM_DEPTH];
    logic [cfp_pkg::TAB_GROUPS-1:0] r_tab_q;
    logic [7:0]                     r_par_q;

    // clearing pass after reset
    logic           r_clr_busy;
    logic [TAW-1:0] r_clr_row;

    // read stage: word waiting on its memory data, plus forwarded data
    logic                           r_s1_vld;
    cfp_pkg::t_in_word              r_s1_word;
    logic                           r_s1_tab_hit;
    logic [cfp_pkg::TAB_GROUPS-1:0] r_s1_tab_fwd;
    logic                           r_s1_par_hit;
    logic [7:0]                     r_s1_par_fwd;

    // parser state
    t_state     r_state,  n_state;
    logic [1:0] r_group,  n_group;
    logic [7:0] r_code,   n_code;
    logic [7:0] r_sub,    n_sub;
    logic [7:0] r_len,    n_len;
    logic [7:0] r_count,  n_count;

    // output register
    logic               r_out_vld;
    cfp_pkg::t_out_word r_out_word;

    // memory port signals
    logic                           in_accept;
    logic [TAW-1:0]                 tab_raddr;
    logic [TAW-1:0]                 tab_waddr;
    logic [cfp_pkg::TAB_GROUPS-1:0] tab_wdata;
    logic                           tab_we;
    logic [PAW-1:0]                 par_raddr;
    logic [PAW-1:0]                 par_waddr;
    logic                           par_we;

    // read stage logic
    logic [cfp_pkg::TAB_GROUPS-1:0] tab_row;
    logic [cfp_pkg::TAB_GROUPS-1:0] cmd_row;
    logic                           cmd_tab_we;
    logic                           cmd_par_we;
    logic [7:0]                     par_byte;
    logic [7:0]                     cnt_inc;
    logic                           has_res;
    cfp_pkg::t_out_word             res;
    logic                           s1_adv;
    logic                           n_s1_vld;

    assign in_accept = i_in_valid && !o_in_stall;

    // a received byte looks up its own value as code, requests use cmd_code
    assign tab_raddr = (i_in_data.req_type == cfp_pkg::REQ_BYTE) ?
                       TAW'(i_in_data.rx_byte) : TAW'(i_in_data.cmd_code);
    assign par_raddr = PAW'(i_in_data.param_index);

    // newest table row, taking a same-row write that raced the read
    assign tab_row  = r_s1_tab_hit ? r_s1_tab_fwd : r_tab_q;
    assign par_byte = r_s1_par_hit ? r_s1_par_fwd : r_par_q;
    assign cnt_inc  = r_count + 8'd1;

    // work out the word's effect on parser state, table and store
    always_comb begin
        n_state    = r_state;
        n_group    = r_group;
        n_code     = r_code;
        n_sub      = r_sub;
        n_len      = r_len;
        n_count    = r_count;
        cmd_row    = tab_row;
        cmd_tab_we = 1'b0;
        cmd_par_we = 1'b0;
        has_res    = 1'b0;
        res        = '0;
        unique case (r_s1_word.req_type)
            cfp_pkg::REQ_BYTE: begin
                unique case (r_state)
                    ST_IDLE: begin
                        n_group = '0;
                        n_code  = '0;
                        n_sub   = '0;
                        n_len   = '0;
                        if (r_s1_word.rx_byte == cfp_pkg::START_BYTE) begin
                            n_state = ST_CMD1;
                        end
                    end
                    ST_CMD1: begin
                        // low six bits must be clear, top two pick the group
                        if ((r_s1_word.rx_byte & cfp_pkg::LOW6_MASK) != 8'h00) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_group = 2'((r_s1_word.rx_byte & cfp_pkg::GROUP_MASK) >> 6);
                            n_state = ST_CODE;
                        end
                    end
                    ST_CODE: begin
                        if (tab_row[r_group]) begin
                            n_code  = r_s1_word.rx_byte;
                            n_state = ST_SUB;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    ST_SUB: begin
                        n_sub   = r_s1_word.rx_byte;
                        n_state = ST_LEN;
                    end
                    ST_LEN: begin
                        n_len = r_s1_word.rx_byte;
                        if (r_s1_word.rx_byte != 8'h00) begin
                            n_count = '0;
                            n_state = ST_PARM;
                        end else begin
                            n_state = ST_TAIL;
                        end
                    end
                    ST_PARM: begin
                        cmd_par_we = 1'b1;
                        if (cnt_inc == r_len) begin
                            n_count = '0;
                            n_state = ST_TAIL;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                    ST_TAIL: begin
                        n_state = ST_IDLE;
                        if (r_s1_word.rx_byte == cfp_pkg::TAIL_BYTE) begin
                            has_res             = 1'b1;
                            res.result_kind     = cfp_pkg::KIND_FRAME;
                            res.success         = 1'b1;
                            res.frame_group     = r_group;
                            res.frame_code      = r_code;
                            res.frame_subcode   = r_sub;
                            res.frame_param_len = r_len;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            cfp_pkg::REQ_REG: begin
                has_res         = 1'b1;
                res.result_kind = cfp_pkg::KIND_REG;
                res.success     = !tab_row[r_s1_word.cmd_group];
                cmd_row[r_s1_word.cmd_group] = 1'b1;
                cmd_tab_we      = !tab_row[r_s1_word.cmd_group];
            end
            cfp_pkg::REQ_UNREG: begin
                has_res         = 1'b1;
                res.result_kind = cfp_pkg::KIND_UNREG;
                res.success     = tab_row[r_s1_word.cmd_group];
                cmd_row[r_s1_word.cmd_group] = 1'b0;
                cmd_tab_we      = tab_row[r_s1_word.cmd_group];
            end
            cfp_pkg::REQ_READ: begin
                has_res         = 1'b1;
                res.result_kind = cfp_pkg::KIND_READ;
                res.success     = 1'b1;
                res.param_data  = par_byte;
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    // a word with a result needs room in the output register
    assign s1_adv     = r_s1_vld && (!has_res || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_vld && !s1_adv);
    assign n_s1_vld   = in_accept || (r_s1_vld && !s1_adv);

    // write ports: clearing pass owns the table until done
    assign tab_we    = r_clr_busy || (s1_adv && cmd_tab_we);
    assign tab_waddr = r_clr_busy ? r_clr_row : TAW'(r_s1_word.cmd_code);
    assign tab_wdata = r_clr_busy ? '0 : cmd_row;
    assign par_we    = s1_adv && cmd_par_we;
    assign par_waddr = PAW'(r_count);

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        if (in_accept) begin
            r_tab_q <= r_tab_mem[tab_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_par_mem[par_waddr] <= r_s1_word.rx_byte;
        end
        if (in_accept) begin
            r_par_q <= r_par_mem[par_raddr];
        end
    end

    // read stage payload and forwarding capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_word    <= i_in_data;
            r_s1_tab_hit <= tab_we && (tab_waddr == tab_raddr);
            r_s1_tab_fwd <= tab_wdata;
            r_s1_par_hit <= par_we && (par_waddr == par_raddr);
            r_s1_par_fwd <= r_s1_word.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_s1_vld   <= 1'b0;
            r_state    <= ST_IDLE;
            r_group    <= '0;
            r_code     <= '0;
            r_sub      <= '0;
            r_len      <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + TAW'(1);
                if (r_clr_row == TAW'(cfp_pkg::TAB_ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_vld <= n_s1_vld;
            if (s1_adv) begin
                r_state <= n_state;
                r_group <= n_group;
                r_code  <= n_code;
                r_sub   <= n_sub;
                r_len   <= n_len;
                r_count <= n_count;
            end
            if (s1_adv && has_res) begin
                r_out_vld  <= 1'b1;
                r_out_word <= res;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_word;

endmodule

// ===== sv/cfp_checker.sv =====
`timescale 1ns / 1ps

module cfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cfp_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cfp_pkg::t_out_word o_out_data
);

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |-> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // table clearing pass keeps the input closed right after reset
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input open during table clearing");

    // frames and reads always report success
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_kind == cfp_pkg::KIND_FRAME ||
                        o_out_data.result_kind == cfp_pkg::KIND_READ)
        |-> o_out_data.success)
        else $error("frame or read without success");

    // parameter data only on read answers
    a_param_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind != cfp_pkg::KIND_READ
        |-> o_out_data.param_data == 8'h00)
        else $error("stray parameter data");

endmodule

bind command_frame_parser_core cfp_checker u_cfp_checker (.*);

// ===== sim/tb_command_frame_parser_core.sv =====
`timescale 1ns / 1ps

module tb_command_frame_parser_core;

    // parser phases, kept local to the bench
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_CMD1,
        PS_CODE,
        PS_SUB,
        PS_LEN,
        PS_PARM,
        PS_TAIL
    } t_parse_state;

    // one row of the opening script: a word and, where obvious, its answer
    typedef struct {
        cfp_pkg::t_in_word  word;
        bit                 typed;
        cfp_pkg::t_out_word ans;
    } t_script_row;

    // codes that registers and unregisters lean on, so that they collide often
    localparam logic [47:0] CODE_POOL = {8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'h81};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    cfp_pkg::t_in_word  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    cfp_pkg::t_out_word out_data;

    // shadow copy of the parser, advanced on every accepted word
    t_parse_state ps_state = PS_IDLE;
    bit           code_tab [0:1023];
    logic [1:0]   f_group = '0;
    logic [7:0]   f_code = '0;
    logic [7:0]   f_sub = '0;
    logic [7:0]   f_len = '0;
    logic [7:0]   p_count = '0;
    logic [7:0]   p_store [0:255];
    bit           p_written [0:255];

    cfp_pkg::t_out_word answers_due [$];
    cfp_pkg::t_out_word want;
    t_script_row        script [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int words_sent = 0;
    int mismatches = 0;

    command_frame_parser_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run (reset sweep included)
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // word with random filler in the fields that its request ignores
    function automatic cfp_pkg::t_in_word mk_word(logic [1:0] req, logic [1:0] grp,
                                                  logic [7:0] val);
        logic [31:0]       r;
        cfp_pkg::t_in_word w;
        r = $urandom;
        w = r[$bits(cfp_pkg::t_in_word)-1:0];
        w.req_type = req;
        case (req)
            cfp_pkg::REQ_BYTE: w.rx_byte = val;
            cfp_pkg::REQ_READ: w.param_index = val;
            default: begin
                w.cmd_group = grp;
                w.cmd_code  = val;
            end
        endcase
        return w;
    endfunction

    function automatic cfp_pkg::t_out_word mk_ans(logic [1:0] kind, logic ok,
                                                  logic [1:0] grp, logic [7:0] code,
                                                  logic [7:0] sub, logic [7:0] len,
                                                  logic [7:0] data);
        cfp_pkg::t_out_word a;
        a.result_kind     = kind;
        a.success         = ok;
        a.frame_group     = grp;
        a.frame_code      = code;
        a.frame_subcode   = sub;
        a.frame_param_len = len;
        a.param_data      = data;
        return a;
    endfunction

    // advances the shadow parser by one word; returns 1 when the word yields an answer
    function automatic bit parser_answer(input cfp_pkg::t_in_word w,
                                         output cfp_pkg::t_out_word ans);
        logic [9:0] slot;
        logic [7:0] b;
        logic [7:0] grp_bits;
        bit         got;
        slot = {w.cmd_group, w.cmd_code};
        b    = w.rx_byte;
        ans  = '0;
        got  = 1'b1;
        case (w.req_type)
            cfp_pkg::REQ_BYTE: begin
                got = 1'b0;
                case (ps_state)
                    PS_IDLE: begin
                        // every idle byte wipes the header fields
                        f_group = '0;
                        f_code  = '0;
                        f_sub   = '0;
                        f_len   = '0;
                        if (b == cfp_pkg::START_BYTE)
                            ps_state = PS_CMD1;
                    end
                    PS_CMD1: begin
                        if ((b & cfp_pkg::LOW6_MASK) != 8'd0) begin
                            ps_state = PS_IDLE;
                        end else begin
                            grp_bits = b & cfp_pkg::GROUP_MASK;
                            f_group  = grp_bits[7:6];
                            ps_state = PS_CODE;
                        end
                    end
                    PS_CODE: begin
                        if (code_tab[{f_group, b}]) begin
                            f_code   = b;
                            ps_state = PS_SUB;
                        end else begin
                            ps_state = PS_IDLE;
                        end
                    end
                    PS_SUB: begin
                        f_sub    = b;
                        ps_state = PS_LEN;
                    end
                    PS_LEN: begin
                        f_len = b;
                        if (b != 8'd0) begin
                            p_count  = '0;
                            ps_state = PS_PARM;
                        end else begin
                            ps_state = PS_TAIL;
                        end
                    end
                    PS_PARM: begin
                        p_store[p_count]   = b;
                        p_written[p_count] = 1'b1;
                        p_count = p_count + 8'd1;
                        if (p_count == f_len) begin
                            p_count  = '0;
                            ps_state = PS_TAIL;
                        end
                    end
                    PS_TAIL: begin
                        ps_state = PS_IDLE;
                        if (b == cfp_pkg::TAIL_BYTE) begin
                            got = 1'b1;
                            ans = mk_ans(cfp_pkg::KIND_FRAME, 1'b1, f_group, f_code, f_sub,
                                         f_len, 8'd0);
                        end
                    end
                    default: ps_state = PS_IDLE;
                endcase
            end
            cfp_pkg::REQ_REG: begin
                ans.result_kind = cfp_pkg::KIND_REG;
                if (!code_tab[slot]) begin
                    code_tab[slot] = 1'b1;
                    ans.success    = 1'b1;
                end
            end
            cfp_pkg::REQ_UNREG: begin
                ans.result_kind = cfp_pkg::KIND_UNREG;
                if (code_tab[slot]) begin
                    code_tab[slot] = 1'b0;
                    ans.success    = 1'b1;
                end
            end
            default: begin
                ans.result_kind = cfp_pkg::KIND_READ;
                ans.success     = 1'b1;
                ans.param_data  = p_store[w.param_index];
            end
        endcase
        return got;
    endfunction

    task automatic check_field(string fld, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ERROR: %s expected %h got %h", $time, fld, exp_v, act_v);
            mismatches++;
        end
    endtask

    // hold the word until taken, then queue up its answer
    task automatic send_word(input cfp_pkg::t_in_word w, input bit typed,
                             input cfp_pkg::t_out_word typed_ans);
        cfp_pkg::t_out_word ans;
        bit                 got;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        words_sent++;
        got = parser_answer(w, ans);
        if (typed)
            answers_due.push_back(typed_ans);
        else if (got)
            answers_due.push_back(ans);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(mk_word(cfp_pkg::REQ_BYTE, 2'd0, b), 1'b0, '0);
    endtask

    // reads only touch bytes that some frame has already stored
    task automatic send_req(input logic [1:0] req);
        logic [7:0] pick;
        int         n;
        int         k;
        int         i;
        pick = '0;
        if (req == cfp_pkg::REQ_READ) begin
            n = 0;
            for (i = 0; i < 256; i++)
                if (p_written[i])
                    n++;
            if (n == 0)
                return;
            k = $urandom_range(n - 1);
            for (i = 0; i < 256; i++) begin
                if (p_written[i]) begin
                    if (k == 0)
                        pick = 8'(i);
                    k--;
                end
            end
            send_word(mk_word(cfp_pkg::REQ_READ, 2'd0, pick), 1'b0, '0);
        end else begin
            if ($urandom_range(9) < 7)
                pick = CODE_POOL[8 * $urandom_range(5) +: 8];
            else
                pick = 8'($urandom);
            send_word(mk_word(req, 2'($urandom), pick), 1'b0, '0);
        end
    endtask

    // one frame on a registered code, now and then broken on purpose
    task automatic send_frame(input bit longest);
        logic [7:0] frame_q [$];
        logic [9:0] slot;
        logic [7:0] b;
        int         n;
        int         k;
        int         i;
        int         len;
        int         fault;
        n    = 0;
        slot = '0;
        for (i = 0; i < 1024; i++)
            if (code_tab[i])
                n++;
        if (n == 0) begin
            slot = 10'($urandom);
            send_word(mk_word(cfp_pkg::REQ_REG, slot[9:8], slot[7:0]), 1'b0, '0);
        end else begin
            k = $urandom_range(n - 1);
            for (i = 0; i < 1024; i++) begin
                if (code_tab[i]) begin
                    if (k == 0)
                        slot = 10'(i);
                    k--;
                end
            end
        end
        if (longest)
            len = 255;
        else if ($urandom_range(999) < 15)
            len = $urandom_range(255, 128);
        else
            len = $urandom_range(8);

        frame_q.push_back(cfp_pkg::START_BYTE);
        frame_q.push_back({slot[9:8], 6'd0});
        frame_q.push_back(slot[7:0]);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'(len));
        for (i = 0; i < len; i++)
            frame_q.push_back(8'($urandom));
        frame_q.push_back(cfp_pkg::TAIL_BYTE);

        fault = longest ? 99 : $urandom_range(99);
        if (fault < 8) begin
            // command byte with some low bit set
            b = 8'($urandom);
            if ((b & cfp_pkg::LOW6_MASK) == 8'd0)
                b[0] = 1'b1;
            frame_q[1] = b;
        end else if (fault < 16) begin
            // code not in the table for this group
            for (i = 0; i < 50; i++) begin
                b = 8'($urandom);
                if (!code_tab[{slot[9:8], b}]) begin
                    frame_q[2] = b;
                    break;
                end
            end
        end else if (fault < 24) begin
            b = 8'($urandom);
            if (b == cfp_pkg::TAIL_BYTE)
                b = b ^ 8'h01;
            frame_q[frame_q.size() - 1] = b;
        end else if (fault < 30) begin
            k = $urandom_range(frame_q.size() - 1, 1);
            while (frame_q.size() > k)
                void'(frame_q.pop_back());
        end

        for (i = 0; i < frame_q.size(); i++) begin
            // reads slipped into a frame see its bytes as they land
            if (i > 0 && $urandom_range(99) < 4)
                send_req(cfp_pkg::REQ_READ);
            send_byte(frame_q[i]);
        end
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
    end

    // every word taken from the output is matched against the oldest answer due
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (answers_due.size() == 0) begin
                $display("%0t ERROR: result with nothing expected, expected none got %h",
                         $time, out_data);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                check_field("result_kind", 8'(want.result_kind), 8'(out_data.result_kind));
                check_field("success", 8'(want.success), 8'(out_data.success));
                check_field("frame_group", 8'(want.frame_group), 8'(out_data.frame_group));
                check_field("frame_code", want.frame_code, out_data.frame_code);
                check_field("frame_subcode", want.frame_subcode, out_data.frame_subcode);
                check_field("frame_param_len", want.frame_param_len, out_data.frame_param_len);
                check_field("param_data", want.param_data, out_data.param_data);
            end
        end
    end

    initial begin
        int wait_cycles;
        int pick;

        // table starts clear: first register wins, unregister of a clear slot fails
        script.push_back('{mk_word(cfp_pkg::REQ_REG, 2'd0, 8'h00), 1'b1,
                           mk_ans(cfp_pkg::KIND_REG, 1'b1, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0)});
        script.push_back('{mk_word(cfp_pkg::REQ_UNREG, 2'd3, 8'hFF), 1'b1,
                           mk_ans(cfp_pkg::KIND_UNREG, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0)});
        script.push_back('{mk_word(cfp_pkg::REQ_REG, 2'd3, 8'hFF), 1'b1,
                           mk_ans(cfp_pkg::KIND_REG, 1'b1, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0)});
        script.push_back('{mk_word(cfp_pkg::REQ_REG, 2'd3, 8'hFF), 1'b1,
                           mk_ans(cfp_pkg::KIND_REG, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0)});
        // top group, top code, zero length straight to the tail
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::START_BYTE), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::GROUP_MASK), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'hFF), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'hFF), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::TAIL_BYTE), 1'b1,
                           mk_ans(cfp_pkg::KIND_FRAME, 1'b1, 2'd3, 8'hFF, 8'hFF, 8'h00,
                                  8'd0)});
        // second start byte is a bad command byte and must not restart the frame,
        // otherwise the bytes after it would make a good frame on code 00
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::START_BYTE), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::START_BYTE), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h01), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::TAIL_BYTE), 1'b0, '0});
        // code 00 is not registered in group 1
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::START_BYTE), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h40), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        // one parameter byte, then a bad tail: no frame, but the byte is stored
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, cfp_pkg::START_BYTE), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h00), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h01), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'hFF), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_BYTE, 2'd0, 8'h7E), 1'b0, '0});
        script.push_back('{mk_word(cfp_pkg::REQ_READ, 2'd0, 8'h00), 1'b1,
                           mk_ans(cfp_pkg::KIND_READ, 1'b1, 2'd0, 8'd0, 8'd0, 8'd0, 8'hFF)});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_word(script[i].word, script[i].typed, script[i].ans);

        // a full-length frame first, so that reads can reach every index up to 254
        send_frame(1'b1);
        while (words_sent < 1700) begin
            case ((words_sent / 150) % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 57;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 57;
                end
                default: begin
                    tx_idle_pct  = 7;
                    rx_stall_pct = 7;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame(1'b0);
            else if (pick < 75)
                send_req(cfp_pkg::REQ_REG);
            else if (pick < 85)
                send_req(cfp_pkg::REQ_UNREG);
            else if (pick < 95)
                send_req(cfp_pkg::REQ_READ);
            else
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
        end

        in_valid     <= 1'b0;
        rx_stall_pct = 0;
        wait_cycles  = 0;
        while (answers_due.size() != 0 && wait_cycles < 2000) begin
            @(posedge clk);
            wait_cycles++;
        end
        // keep watching to catch anything stray behind the last answer
        repeat (8) @(posedge clk);
        if (answers_due.size() != 0) begin
            $display("%0t ERROR: %0d expected results never arrived", $time,
                     answers_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/cfp_pkg.sv
sv/command_frame_parser_core.sv
sv/cfp_checker.sv
sim/tb_command_frame_parser_core.sv
